// ===== rtl/core/gmf_pkg.sv =====
// gmf_pkg: shared types and constants of the GRIB message framer.
// No dependencies; used by gmf_parser, gmf_out_slot and grib_message_framer.
`default_nettype none

package gmf_pkg;

  localparam logic [31:0] MagicWord   = 32'h4752_4942;  // "GRIB"
  localparam logic [31:0] TrailerWord = 32'h3737_3737;  // "7777"

  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StNoTrailer  = 3'd1;
  localparam logic [2:0] StTruncated  = 3'd2;
  localparam logic [2:0] StBadEdition = 3'd3;
  localparam logic [2:0] StNotFound   = 3'd4;
  localparam logic [2:0] StTooShort   = 3'd5;

  typedef struct packed {
    logic        hit;
    logic [2:0]  status;
    logic [7:0]  edition;
    logic [31:0] length;
    logic [31:0] start;
  } gmf_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/gmf_parser.sv =====
// gmf_parser: framing state and single-pass per-byte update.
// Depends on gmf_pkg.
`default_nettype none

module gmf_parser #(
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             end_of_data_i,
  output gmf_pkg::gmf_res_t     res_o
);

  localparam logic [1:0] PhHunt   = 2'd0;
  localparam logic [1:0] PhHeader = 2'd1;
  localparam logic [1:0] PhBody   = 2'd2;

  logic [1:0]                phase_q, phase_d;
  logic [31:0]               recent_q, recent_d;
  logic [POSITION_WIDTH-1:0] fpos_q, fpos_d;
  logic [POSITION_WIDTH-1:0] mstart_q, mstart_d;
  logic [31:0]               bim_q, bim_d;
  logic [7:0]                ed_q, ed_d;
  logic [31:0]               dl_q, dl_d;

  logic [31:0]               recent_n;
  logic [31:0]               dl_shift;
  logic [31:0]               bim_inc;
  logic [31:0]               lk_len;
  logic [POSITION_WIDTH-1:0] pos_inc;
  logic [POSITION_WIDTH-1:0] pos_magic;
  gmf_pkg::gmf_res_t         res;

  assign recent_n  = {recent_q[23:0], data_byte_i};
  assign dl_shift  = {dl_q[23:0], data_byte_i};
  assign bim_inc   = bim_q + 32'd1;
  assign pos_inc   = fpos_q + POSITION_WIDTH'(1);
  assign pos_magic = fpos_q - POSITION_WIDTH'(3);
  // length becomes known at offset 7 (editions 0/1) or offset 15 (edition 2)
  assign lk_len    = (bim_q == 32'd7) ? dl_q : dl_shift;

  always_comb begin
    phase_d    = phase_q;
    recent_d   = recent_n;
    fpos_d     = pos_inc;
    mstart_d   = mstart_q;
    bim_d      = bim_q;
    ed_d       = ed_q;
    dl_d       = dl_q;
    res.hit    = 1'b0;
    res.status = gmf_pkg::StOk;
    res.edition = 8'd0;
    res.length = 32'd0;
    res.start  = 32'(64'(mstart_q));

    unique case (phase_q)
      PhHunt: begin
        if (recent_n == gmf_pkg::MagicWord) begin
          mstart_d = pos_magic;
          bim_d    = 32'd4;
          dl_d     = 32'd0;
          ed_d     = 8'd0;
          phase_d  = PhHeader;
          if (end_of_data_i) begin
            res.hit    = 1'b1;
            res.status = gmf_pkg::StTruncated;
            res.start  = 32'(64'(pos_magic));
          end
        end else if (end_of_data_i) begin
          res.hit    = 1'b1;
          res.status = gmf_pkg::StNotFound;
          res.start  = 32'(64'(pos_inc));
        end
      end
      PhHeader: begin
        bim_d = bim_inc;
        if (bim_q >= 32'd4 && bim_q <= 32'd6) begin
          dl_d = dl_shift;
        end else if (bim_q == 32'd7) begin
          ed_d = data_byte_i;
          if (data_byte_i == 8'd2) begin
            dl_d = 32'd0;
          end else if (data_byte_i > 8'd2) begin
            res.hit     = 1'b1;
            res.status  = gmf_pkg::StBadEdition;
            res.edition = data_byte_i;
          end
        end else if (bim_q >= 32'd12 && bim_q <= 32'd15) begin
          dl_d = dl_shift;
        end
        if ((bim_q == 32'd7 && data_byte_i <= 8'd1) || bim_q == 32'd15) begin
          if (lk_len < bim_inc) begin
            res.hit     = 1'b1;
            res.status  = gmf_pkg::StTooShort;
            res.edition = ed_d;
            res.length  = lk_len;
          end else if (lk_len == bim_inc) begin
            res.hit     = 1'b1;
            res.status  = (recent_n == gmf_pkg::TrailerWord) ?
                          gmf_pkg::StOk : gmf_pkg::StNoTrailer;
            res.edition = ed_d;
            res.length  = lk_len;
          end else begin
            phase_d = PhBody;
          end
        end
        if (!res.hit && end_of_data_i) begin
          res.hit     = 1'b1;
          res.status  = gmf_pkg::StTruncated;
          res.edition = (bim_q >= 32'd7) ? ed_d : 8'd0;
          res.length  = (phase_d == PhBody) ? dl_d : 32'd0;
        end
      end
      PhBody: begin
        bim_d = bim_inc;
        if (bim_inc == dl_q) begin
          res.hit     = 1'b1;
          res.status  = (recent_n == gmf_pkg::TrailerWord) ?
                        gmf_pkg::StOk : gmf_pkg::StNoTrailer;
          res.edition = ed_q;
          res.length  = dl_q;
        end else if (end_of_data_i) begin
          res.hit     = 1'b1;
          res.status  = gmf_pkg::StTruncated;
          res.edition = ed_q;
          res.length  = dl_q;
        end
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase

    if (res.hit) begin
      phase_d  = PhHunt;
      recent_d = 32'd0;
    end
    if (end_of_data_i) begin
      fpos_d   = '0;
      recent_d = 32'd0;
      phase_d  = PhHunt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      recent_q <= 32'd0;
      fpos_q   <= '0;
      mstart_q <= '0;
      bim_q    <= 32'd0;
      ed_q     <= 8'd0;
      dl_q     <= 32'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      recent_q <= recent_d;
      fpos_q   <= fpos_d;
      mstart_q <= mstart_d;
      bim_q    <= bim_d;
      ed_q     <= ed_d;
      dl_q     <= dl_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

// ===== rtl/core/gmf_out_slot.sv =====
// gmf_out_slot: result register with valid/ready on the output side.
// Depends on gmf_pkg.
`default_nettype none

module gmf_out_slot (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire gmf_pkg::gmf_res_t res_i,
  input  wire logic              ready_i,
  output logic                   room_o,
  output logic                   valid_o,
  output logic [2:0]             status_o,
  output logic [7:0]             edition_o,
  output logic [31:0]            length_o,
  output logic [31:0]            start_o
);

  logic        valid_q;
  logic [2:0]  status_q;
  logic [7:0]  edition_q;
  logic [31:0] length_q;
  logic [31:0] start_q;

  assign room_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q  <= res_i.status;
      edition_q <= res_i.edition;
      length_q  <= res_i.length;
      start_q   <= res_i.start;
    end
  end

  assign valid_o   = valid_q;
  assign status_o  = status_q;
  assign edition_o = edition_q;
  assign length_o  = length_q;
  assign start_o   = start_q;

endmodule

`default_nettype wire

// ===== rtl/core/grib_message_framer.sv =====
// grib_message_framer: frames GRIB edition 0/1/2 messages in a byte stream.
// A report passes from the input register through the combinational parser
// into the result register.
// Throughput: one byte per cycle; the parser stalls only while a report waits.
// Reset (rst_ni, async, active low) empties both registers and starts hunting
// at file position 0. Depends on gmf_pkg, gmf_parser, gmf_out_slot.
`default_nettype none

module grib_message_framer #(
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [7:0]       edition_o,
  output logic [31:0]      message_length_o,
  output logic [31:0]      start_offset_o
);

  logic              in_valid_q;
  logic [7:0]        byte_q;
  logic              eod_q;
  logic              advance;
  logic              room;
  gmf_pkg::gmf_res_t res;

  // beat held in the input register moves on unless its report has no slot
  assign advance    = in_valid_q && (!res.hit || room);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      eod_q  <= end_of_data_i;
    end
  end

  gmf_parser #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .data_byte_i  (byte_q),
    .end_of_data_i(eod_q),
    .res_o        (res)
  );

  gmf_out_slot u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && res.hit),
    .res_i    (res),
    .ready_i  (out_ready_i),
    .room_o   (room),
    .valid_o  (out_valid_o),
    .status_o (status_o),
    .edition_o(edition_o),
    .length_o (message_length_o),
    .start_o  (start_offset_o)
  );

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= gmf_pkg::StTooShort)
    else $error("report status out of range");

  a_report_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.hit |=> out_valid_o)
    else $error("report lost at result register");

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(byte_q) && $stable(eod_q))
    else $error("stalled input beat changed");

  a_not_found_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == gmf_pkg::StNotFound |->
      edition_o == 8'd0 && message_length_o == 32'd0)
    else $error("not-found report carries message fields");

endmodule

`default_nettype wire

// ===== tb/grib_message_framer_tb.sv =====
// grib_message_framer_tb: self-checking bench that frames random GRIB files through the DUT
// and scores every report against a cycle-free software framer. Depends on gmf_pkg and
// grib_message_framer only.
`default_nettype none

module grib_message_framer_tb;

  localparam int CalmFrom      = 500;
  localparam int CalmTo        = 900;
  localparam int HoldCycles    = 300;
  localparam int StallLimit    = 2000;
  localparam int RandomBytes   = 1050;
  localparam int DrainAtBytes  = 500;

  typedef enum logic [1:0] {SeekMagic, ReadHeader, ReadBody} parse_state_e;

  typedef struct {
    logic [7:0] data;
    logic       eod;
    bit         drain;
  } byte_beat_t;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  edition;
    logic [31:0] length;
    logic [31:0] start;
  } report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        end_of_data_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  edition_o;
  logic [31:0] message_length_o;
  logic [31:0] start_offset_o;

  grib_message_framer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .end_of_data_i   (end_of_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .edition_o       (edition_o),
    .message_length_o(message_length_o),
    .start_offset_o  (start_offset_o)
  );

  always #5 clk_i = ~clk_i;

  // framer model state
  parse_state_e parse_st = SeekMagic;
  logic [31:0]  last4 = '0;
  logic [31:0]  stream_pos = '0;
  logic [31:0]  msg_origin = '0;
  logic [31:0]  hdr_count = '0;
  logic [7:0]   ed_byte = '0;
  logic [31:0]  len_field = '0;

  report_t      pending_reports[$];
  byte_beat_t   byte_q[$];
  byte_beat_t   nxt;

  int  cycle = 0;
  int  quiet_cycles = 0;
  int  mismatches = 0;
  int  bytes_sent = 0;
  int  files_seen = 0;
  int  reports_seen = 0;
  int  status_hits[8];
  int  hold_left = 0;
  bit  hold_used = 1'b0;
  bit  in_taken = 1'b0;
  bit  drain_next = 1'b0;
  bit  drain_set = 1'b0;

  function automatic void post_report(logic [2:0] st, logic [7:0] ed, logic [31:0] len,
                                      logic [31:0] start);
    report_t r;
    r.status = st;
    r.edition = ed;
    r.length = len;
    r.start = start;
    pending_reports.push_back(r);
    parse_st = SeekMagic;
    last4 = '0;
  endfunction

  function automatic void close_message();
    post_report((last4 == gmf_pkg::TrailerWord) ? gmf_pkg::StOk : gmf_pkg::StNoTrailer,
                ed_byte, len_field, msg_origin);
  endfunction

  function automatic bit settle_length();
    if (len_field < hdr_count) begin
      post_report(gmf_pkg::StTooShort, ed_byte, len_field, msg_origin);
      return 1'b1;
    end
    if (len_field == hdr_count) begin
      close_message();
      return 1'b1;
    end
    parse_st = ReadBody;
    return 1'b0;
  endfunction

  function automatic void frame_byte(logic [7:0] b, logic eod);
    logic [31:0] pos;
    logic [31:0] idx;
    bit          done;
    pos = stream_pos;
    done = 1'b0;
    last4 = {last4[23:0], b};
    case (parse_st)
      SeekMagic: begin
        if (last4 == gmf_pkg::MagicWord) begin
          msg_origin = pos - 32'd3;
          hdr_count = 32'd4;
          len_field = '0;
          ed_byte = '0;
          parse_st = ReadHeader;
          if (eod) post_report(gmf_pkg::StTruncated, 8'd0, 32'd0, msg_origin);
        end else if (eod) begin
          post_report(gmf_pkg::StNotFound, 8'd0, 32'd0, pos + 32'd1);
        end
      end
      ReadHeader: begin
        idx = hdr_count;
        hdr_count = idx + 32'd1;
        if (idx >= 4 && idx <= 6) begin
          len_field = {len_field[23:0], b};
        end else if (idx == 7) begin
          ed_byte = b;
          if (b <= 8'd1) begin
            done = settle_length();
          end else if (b == 8'd2) begin
            len_field = '0;
          end else begin
            post_report(gmf_pkg::StBadEdition, b, 32'd0, msg_origin);
            done = 1'b1;
          end
        end else if (idx >= 12 && idx <= 15) begin
          len_field = {len_field[23:0], b};
          if (idx == 15) done = settle_length();
        end
        if (!done && eod)
          post_report(gmf_pkg::StTruncated, (idx >= 7) ? ed_byte : 8'd0,
                      (parse_st == ReadBody) ? len_field : 32'd0, msg_origin);
      end
      default: begin
        hdr_count = hdr_count + 32'd1;
        if (hdr_count == len_field) close_message();
        else if (eod) post_report(gmf_pkg::StTruncated, ed_byte, len_field, msg_origin);
      end
    endcase
    stream_pos = pos + 32'd1;
    if (eod) begin
      stream_pos = '0;
      last4 = '0;
      parse_st = SeekMagic;
    end
  endfunction

  function automatic bit take_break();
    return (cycle < CalmFrom || cycle >= CalmTo) && ($urandom_range(99) < 26);
  endfunction

  task automatic add_byte(logic [7:0] b, logic eod);
    byte_beat_t t;
    t.data = b;
    t.eod = eod;
    t.drain = drain_next;
    drain_next = 1'b0;
    byte_q.push_back(t);
  endtask

  task automatic add_noise(int n, bit eod_last);
    for (int i = 0; i < n; i++) add_byte(8'($urandom), eod_last && (i == n - 1));
  endtask

  // cut > 0 ends the file after that many bytes of the message
  task automatic add_message(logic [7:0] ed, logic [31:0] len, bit good_tail, int cut);
    logic [7:0] m[$];
    longint     hdr;
    longint     total;
    longint     stop;
    hdr = (ed == 8'd2) ? 16 : 8;
    total = len;
    m = '{8'h47, 8'h52, 8'h49, 8'h42};
    if (ed == 8'd2) begin
      repeat (3) m.push_back(8'($urandom));
      m.push_back(ed);
      repeat (4) m.push_back(8'($urandom));
      m.push_back(len[31:24]);
      m.push_back(len[23:16]);
      m.push_back(len[15:8]);
      m.push_back(len[7:0]);
    end else begin
      m.push_back(len[23:16]);
      m.push_back(len[15:8]);
      m.push_back(len[7:0]);
      m.push_back(ed);
    end
    if (cut > 0) stop = cut;
    else if (ed > 8'd2) stop = 8;
    else stop = (total > hdr) ? total : hdr;
    while (m.size() < stop) begin
      if (good_tail && m.size() >= total - 4 && m.size() >= hdr) m.push_back(8'h37);
      else m.push_back(8'($urandom));
    end
    while (m.size() > stop) void'(m.pop_back());
    foreach (m[i]) add_byte(m[i], (cut > 0) && (i == m.size() - 1));
  endtask

  task automatic add_random_case();
    int          pick;
    logic [7:0]  ed;
    logic [31:0] len;
    int          hdr;
    pick = $urandom_range(99);
    ed = 8'($urandom_range(2));
    hdr = (ed == 8'd2) ? 16 : 8;
    if (pick < 60) begin
      len = hdr + 4 + $urandom_range(36);
      add_message(ed, len, 1'b1, ($urandom_range(9) == 0) ? int'(len) : 0);
    end else if (pick < 68) begin
      add_message(ed, hdr + 1 + $urandom_range(30), 1'b0, 0);
    end else if (pick < 74) begin
      len = hdr + 4 + $urandom_range(36);
      add_message(ed, len, 1'b1, 1 + $urandom_range(int'(len) - 2));
    end else if (pick < 79) begin
      add_message(8'($urandom_range(255, 3)), 32'($urandom_range(60)), 1'b0, 0);
    end else if (pick < 84) begin
      add_message(ed, 32'($urandom_range(hdr)), 1'b1, 0);
    end else if (pick < 94) begin
      add_noise(1 + $urandom_range(7), 1'b0);
    end else begin
      add_noise(1 + $urandom_range(7), 1'b1);
    end
  endtask

  // input beats and result beats, scoring and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle++;
      quiet_cycles++;
      if (in_valid_i && in_ready_o) begin
        frame_byte(data_byte_i, end_of_data_i);
        bytes_sent++;
        if (end_of_data_i) files_seen++;
        in_taken = 1'b1;
        quiet_cycles = 0;
      end
      if (out_valid_o && out_ready_i) begin
        report_t exp_r;
        quiet_cycles = 0;
        reports_seen++;
        status_hits[status_o]++;
        if (pending_reports.size() == 0) begin
          $error("unexpected report: status %0d start %0d", status_o, start_offset_o);
          mismatches++;
        end else begin
          exp_r = pending_reports.pop_front();
          if (status_o !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_o);
            mismatches++;
          end
          if (edition_o !== exp_r.edition) begin
            $error("edition: expected %0d, got %0d", exp_r.edition, edition_o);
            mismatches++;
          end
          if (message_length_o !== exp_r.length) begin
            $error("message_length: expected %0d, got %0d", exp_r.length, message_length_o);
            mismatches++;
          end
          if (start_offset_o !== exp_r.start) begin
            $error("start_offset: expected %0d, got %0d", exp_r.start, start_offset_o);
            mismatches++;
          end
        end
      end
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no beat for %0d cycles", StallLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // byte driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      in_taken = 1'b0;
      if (byte_q.size() > 0 && !(byte_q[0].drain && pending_reports.size() > 0) &&
          !take_break()) begin
        nxt = byte_q.pop_front();
        in_valid_i <= 1'b1;
        data_byte_i <= nxt.data;
        end_of_data_i <= nxt.eod;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // report sink, with one long hold-off to back the framer up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_used && reports_seen >= 15) begin
        hold_used = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !take_break();
      end
    end
  end

  initial begin
    // directed: not found, magic on last byte, each edition, the length corner cases
    add_noise(3, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_message(8'd1, 32'd20, 1'b1, 4);
    add_message(8'd0, 32'd12, 1'b1, 0);
    add_message(8'd1, 32'd30, 1'b1, 0);
    add_message(8'd2, 32'd24, 1'b1, 0);
    add_message(8'd1, 32'd16, 1'b0, 0);
    add_message(8'd1, 32'd8, 1'b1, 0);
    add_message(8'd2, 32'd16, 1'b1, 0);
    add_message(8'd0, 32'd0, 1'b1, 0);
    add_message(8'd2, 32'd15, 1'b1, 0);
    add_message(8'd3, 32'd20, 1'b1, 0);
    add_message(8'd255, 32'd20, 1'b1, 0);
    add_message(8'd1, 32'd30, 1'b1, 6);
    add_message(8'd2, 32'd30, 1'b1, 12);
    add_message(8'd1, 32'h00FF_FFFF, 1'b1, 20);
    add_message(8'd2, 32'hFFFF_FFFF, 1'b1, 24);
    add_message(8'd2, 32'd20, 1'b1, 20);
    add_noise(2, 1'b0);
    add_message(8'd0, 32'd40, 1'b1, 30);

    while (byte_q.size() < RandomBytes) begin
      if (!drain_set && byte_q.size() >= DrainAtBytes) begin
        drain_set = 1'b1;
        drain_next = 1'b1;
      end
      add_random_case();
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_q.size() > 0 || in_valid_i) @(negedge clk_i);
    while (pending_reports.size() > 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Sent %0d bytes over %0d files; %0d reports checked.",
             bytes_sent, files_seen, reports_seen);
    $display("ok %0d, no trailer %0d, truncated %0d, bad edition %0d, none %0d, short %0d",
             status_hits[gmf_pkg::StOk], status_hits[gmf_pkg::StNoTrailer],
             status_hits[gmf_pkg::StTruncated], status_hits[gmf_pkg::StBadEdition],
             status_hits[gmf_pkg::StNotFound], status_hits[gmf_pkg::StTooShort]);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/gmf_pkg.sv
rtl/core/gmf_parser.sv
rtl/core/gmf_out_slot.sv
rtl/core/grib_message_framer.sv
tb/grib_message_framer_tb.sv
